FILE: rtl/cbu_pkg.sv
// Shared types and constants for the color blend unit.
`default_nettype none
package cbu_pkg;

   localparam int unsigned CH_W    = 8;   // color channel width
   localparam int unsigned AMT_W   = 9;   // blend amount width, 256 is 1.0
   localparam int unsigned PROD_W  = 16;  // channel times amount products
   localparam int unsigned LUM_W   = 17;  // weighted luminance sum
   localparam int unsigned DIFF_W  = LUM_W + 1;
   localparam int unsigned DT_W    = 26;  // luminance difference times amount
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [AMT_W-1:0] AMT_ONE = AMT_W'(256);

   // Luminance weights over 256.
   localparam logic [LUM_W-1:0] LUM_WT_RED   = LUM_W'(54);
   localparam logic [LUM_W-1:0] LUM_WT_GREEN = LUM_W'(183);
   localparam logic [LUM_W-1:0] LUM_WT_BLUE  = LUM_W'(19);

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRUSH_RED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRUSH_GREEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRUSH_BLUE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BRUSH_ALPHA = 3'd4;

   typedef enum logic [2:0] {
      MODE_MIX      = 3'd0,
      MODE_ADD      = 3'd1,
      MODE_SUBTRACT = 3'd2,
      MODE_MULTIPLY = 3'd3,
      MODE_LIGHTEN  = 3'd4,
      MODE_DARKEN   = 3'd5,
      MODE_COLOR    = 3'd6
   } blend_mode_type;

endpackage
`default_nettype wire

FILE: rtl/cbu_channel.sv
// Five-stage blend pipeline for one color channel.
`default_nettype none
module cbu_channel (
   input  wire logic                         clock,
   input  wire logic                         advance,
   input  wire cbu_pkg::blend_mode_type      mode_in,
   input  wire logic [cbu_pkg::CH_W-1:0]     base_in,
   input  wire logic [cbu_pkg::CH_W-1:0]     brush_in,
   input  wire logic [cbu_pkg::AMT_W-1:0]    amount_in,
   input  wire logic signed [cbu_pkg::DT_W-1:0] dt_in,
   output logic [cbu_pkg::CH_W-1:0]          value_out
);
   import cbu_pkg::*;

   // Stage 1: the two products of the linear blend.
   blend_mode_type      mode1_ff;
   logic [CH_W-1:0]     base1_ff;
   logic [AMT_W-1:0]    amt1_ff;
   logic [PROD_W-1:0]   pb1_ff, pc1_ff;
   logic [AMT_W-1:0]    inv_amt;
   logic [PROD_W:0]     pb_prod, pc_prod;

   assign inv_amt = AMT_ONE - amount_in;
   assign pb_prod = {{(PROD_W+1-CH_W){1'b0}}, base_in} * {{(PROD_W+1-AMT_W){1'b0}}, inv_amt};
   assign pc_prod = {{(PROD_W+1-CH_W){1'b0}}, brush_in} * {{(PROD_W+1-AMT_W){1'b0}}, amount_in};

   always_ff @(posedge clock) begin
      if (advance) begin
         mode1_ff <= mode_in;
         base1_ff <= base_in;
         amt1_ff  <= amount_in;
         pb1_ff   <= pb_prod[PROD_W-1:0];
         pc1_ff   <= pc_prod[PROD_W-1:0];
      end
   end

   // Stage 2: rounded mix, rounded brush scale and the multiply factor.
   blend_mode_type      mode2_ff;
   logic [CH_W-1:0]     base2_ff, mix2_ff, scl2_ff;
   logic [PROD_W-1:0]   mixnum2_ff, fact2_ff;
   logic [PROD_W:0]     mixnum_in, mix_rnd, scl_rnd, amt255, fact_in;

   assign mixnum_in = {1'b0, pb1_ff} + {1'b0, pc1_ff};
   assign mix_rnd   = mixnum_in + (PROD_W+1)'(128);
   assign scl_rnd   = {1'b0, pc1_ff} + (PROD_W+1)'(128);
   assign amt255    = {amt1_ff, 8'b0} - {{(PROD_W+1-AMT_W){1'b0}}, amt1_ff};
   assign fact_in   = (PROD_W+1)'(65280) - amt255 + {1'b0, pc1_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         mode2_ff   <= mode1_ff;
         base2_ff   <= base1_ff;
         mixnum2_ff <= mixnum_in[PROD_W-1:0];
         mix2_ff    <= mix_rnd[15:8];
         scl2_ff    <= scl_rnd[15:8];
         fact2_ff   <= fact_in[PROD_W-1:0];
      end
   end

   // Stage 3: simple modes resolve; multiply and color form their wide terms.
   blend_mode_type      mode3_ff;
   logic [CH_W-1:0]     res3_ff;
   logic [15:0]         quo3_ff;
   logic signed [27:0]  total3_ff;
   logic [CH_W-1:0]     res3_in;
   logic [CH_W:0]       add_sum;
   logic [23:0]         mul_sum;
   logic signed [27:0]  total_in;

   assign add_sum  = {1'b0, base2_ff} + {1'b0, scl2_ff};
   assign mul_sum  = {16'b0, base2_ff} * {8'b0, fact2_ff} + 24'd32640;
   assign total_in = $signed({3'b0, mixnum2_ff, 9'b0})
                   + $signed({{(28-DT_W){dt_in[DT_W-1]}}, dt_in})
                   + 28'sd65536;

   always_comb begin
      unique case (mode2_ff)
         MODE_ADD:      res3_in = add_sum[CH_W] ? 8'hFF : add_sum[CH_W-1:0];
         MODE_SUBTRACT: res3_in = (scl2_ff > base2_ff) ? 8'h00 : base2_ff - scl2_ff;
         MODE_LIGHTEN:  res3_in = (mix2_ff > base2_ff) ? mix2_ff : base2_ff;
         MODE_DARKEN:   res3_in = (mix2_ff < base2_ff) ? mix2_ff : base2_ff;
         default:       res3_in = mix2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode3_ff  <= mode2_ff;
         res3_ff   <= res3_in;
         quo3_ff   <= mul_sum[23:8];   // first divide by 256 of the 65280 divisor
         total3_ff <= total_in;
      end
   end

   // Stage 4: color clamp and a reciprocal estimate of the divide by 255.
   logic                is_mul4_ff;
   logic [CH_W-1:0]     res4_ff, qest4_ff;
   logic [15:0]         quo4_ff;
   logic [24:0]         recip_prod;
   logic [CH_W-1:0]     color_val;

   // The estimate is low by at most one.
   assign recip_prod = {9'b0, quo3_ff} * 25'd257;

   always_comb begin
      if (total3_ff[27]) begin
         color_val = 8'h00;
      end else if (total3_ff[26:25] != 2'b00) begin
         color_val = 8'hFF;
      end else begin
         color_val = total3_ff[24:17];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         is_mul4_ff <= (mode3_ff == MODE_MULTIPLY);
         res4_ff    <= (mode3_ff == MODE_COLOR) ? color_val : res3_ff;
         qest4_ff   <= recip_prod[23:16];
         quo4_ff    <= quo3_ff;
      end
   end

   // Stage 5: correct the estimate and pick the result.
   logic [CH_W-1:0]  value5_ff;
   logic [15:0]      back_prod, remainder;
   logic [CH_W-1:0]  quot;

   assign back_prod = {8'b0, qest4_ff} * 16'd255;
   assign remainder = quo4_ff - back_prod;
   assign quot      = (remainder >= 16'd255) ? qest4_ff + 8'd1 : qest4_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         value5_ff <= is_mul4_ff ? quot : res4_ff;
      end
   end

   assign value_out = value5_ff;

endmodule
`default_nettype wire

FILE: rtl/color_blend_unit.sv
// Top level of the color blend unit: registers, luminance and the channel pipelines.
//
// Blends one RGBA base color toward a programmed brush color by amount t.
// Request channel: req_valid, req_stall and the base color plus mix_amount;
// a transfer happens on a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid, rsp_stall and the blended color, same rule.
// Write the mode and brush color through the csr port while no work is in flight.
// Throughput is one color per cycle while no stalled result holds the
// pipeline; the five register stages are set by the wide multiply and the
// divide-by-65280 (reciprocal estimate, then one correction).
// When the receiver stalls a valid result, the whole pipeline holds and
// req_stall is raised; nothing is dropped or repeated. Bubbles move on while
// the output is empty or being taken.
// Synchronous reset clears all valid bits and loads the register defaults:
// mix mode, black brush, brush alpha 255.
`default_nettype none
module color_blend_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [cbu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cbu_pkg::CH_W-1:0]          csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [cbu_pkg::CH_W-1:0]          req_base_red,
   input  wire logic [cbu_pkg::CH_W-1:0]          req_base_green,
   input  wire logic [cbu_pkg::CH_W-1:0]          req_base_blue,
   input  wire logic [cbu_pkg::CH_W-1:0]          req_base_alpha,
   input  wire logic [cbu_pkg::AMT_W-1:0]         req_mix_amount,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [cbu_pkg::CH_W-1:0]               rsp_out_red,
   output logic [cbu_pkg::CH_W-1:0]               rsp_out_green,
   output logic [cbu_pkg::CH_W-1:0]               rsp_out_blue,
   output logic [cbu_pkg::CH_W-1:0]               rsp_out_alpha
);
   import cbu_pkg::*;

   localparam int unsigned STAGES = 5;

   // Configuration registers.
   blend_mode_type   mode_ff;
   logic [CH_W-1:0]  brush_red_ff, brush_green_ff, brush_blue_ff, brush_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_MIX;
         brush_red_ff   <= '0;
         brush_green_ff <= '0;
         brush_blue_ff  <= '0;
         brush_alpha_ff <= 8'hFF;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BLEND_MODE:  mode_ff        <= blend_mode_type'(csr_data[2:0]);
            CSR_BRUSH_RED:   brush_red_ff   <= csr_data;
            CSR_BRUSH_GREEN: brush_green_ff <= csr_data;
            CSR_BRUSH_BLUE:  brush_blue_ff  <= csr_data;
            CSR_BRUSH_ALPHA: brush_alpha_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline control: everything moves unless a finished result is stalled.
   logic [STAGES-1:0] valid_ff, valid_in;
   logic              advance;

   assign advance   = !(valid_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;
   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Amounts above one saturate.
   logic [AMT_W-1:0] amount;
   logic [AMT_W-1:0] alpha_amount;
   logic             mix_like;

   assign amount       = (req_mix_amount > AMT_ONE) ? AMT_ONE : req_mix_amount;
   // The unused mode code behaves as mix; other modes keep base alpha,
   // which a mix with zero amount returns exactly.
   assign mix_like     = (mode_ff == MODE_MIX) || (mode_ff > MODE_COLOR);
   assign alpha_amount = mix_like ? amount : '0;

   // Luminance difference, then its product with the amount.
   logic [LUM_W-1:0]         lum_brush, lum_base;
   logic signed [DIFF_W-1:0] diff1_ff;
   logic [AMT_W-1:0]         amt1_ff;
   logic signed [DT_W-1:0]   dt2_ff;
   logic signed [DIFF_W+AMT_W:0] dt_full;

   assign lum_brush = LUM_WT_RED * {9'b0, brush_red_ff}
                    + LUM_WT_GREEN * {9'b0, brush_green_ff}
                    + LUM_WT_BLUE * {9'b0, brush_blue_ff};
   assign lum_base  = LUM_WT_RED * {9'b0, req_base_red}
                    + LUM_WT_GREEN * {9'b0, req_base_green}
                    + LUM_WT_BLUE * {9'b0, req_base_blue};
   assign dt_full   = diff1_ff * $signed({1'b0, amt1_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         diff1_ff <= $signed({1'b0, lum_brush}) - $signed({1'b0, lum_base});
         amt1_ff  <= amount;
         dt2_ff   <= dt_full[DT_W-1:0];
      end
   end

   cbu_channel u_red (
      .clock     (clock),
      .advance   (advance),
      .mode_in   (mode_ff),
      .base_in   (req_base_red),
      .brush_in  (brush_red_ff),
      .amount_in (amount),
      .dt_in     (dt2_ff),
      .value_out (rsp_out_red)
   );

   cbu_channel u_green (
      .clock     (clock),
      .advance   (advance),
      .mode_in   (mode_ff),
      .base_in   (req_base_green),
      .brush_in  (brush_green_ff),
      .amount_in (amount),
      .dt_in     (dt2_ff),
      .value_out (rsp_out_green)
   );

   cbu_channel u_blue (
      .clock     (clock),
      .advance   (advance),
      .mode_in   (mode_ff),
      .base_in   (req_base_blue),
      .brush_in  (brush_blue_ff),
      .amount_in (amount),
      .dt_in     (dt2_ff),
      .value_out (rsp_out_blue)
   );

   cbu_channel u_alpha (
      .clock     (clock),
      .advance   (advance),
      .mode_in   (MODE_MIX),
      .base_in   (req_base_alpha),
      .brush_in  (brush_alpha_ff),
      .amount_in (alpha_amount),
      .dt_in     ('0),
      .value_out (rsp_out_alpha)
   );

   assign rsp_valid = valid_ff[STAGES-1];

   // A held pipeline keeps every valid bit in place.
   a_hold_keeps_valid: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("valid bits moved while the pipeline was held");

   // An accepted request occupies the first stage on the next edge.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for color_blend_unit with a built-in blend predictor.
`default_nettype none
module tb_top;
   import cbu_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 12;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int CSR_SLOTS      = 1 << CSR_IDX_W;
   localparam int ITEMS_PER_PHASE = 540;

   // The three-bit mode field has one code with no mode behind it; it acts as mix.
   localparam logic [2:0] MODE_SPARE = 3'd7;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
   } rgba_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CH_W-1:0]      csr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [CH_W-1:0]      req_base_red;
   logic [CH_W-1:0]      req_base_green;
   logic [CH_W-1:0]      req_base_blue;
   logic [CH_W-1:0]      req_base_alpha;
   logic [AMT_W-1:0]     req_mix_amount;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CH_W-1:0]      rsp_out_red;
   logic [CH_W-1:0]      rsp_out_green;
   logic [CH_W-1:0]      rsp_out_blue;
   logic [CH_W-1:0]      rsp_out_alpha;

   // Predictor copy of the programmed registers.
   logic [2:0]      mode_setting;
   logic [CH_W-1:0] brush_red;
   logic [CH_W-1:0] brush_green;
   logic [CH_W-1:0] brush_blue;
   logic [CH_W-1:0] brush_alpha;

   rgba_type expected_colors[$];
   rgba_type oldest_color;
   int    error_count = 0;
   int    send_idle_pct = 0;
   int    recv_idle_pct = 0;

   color_blend_unit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_base_red   (req_base_red),
      .req_base_green (req_base_green),
      .req_base_blue  (req_base_blue),
      .req_base_alpha (req_base_alpha),
      .req_mix_amount (req_mix_amount),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Computes the blended color for one base color under the current registers.
   function automatic rgba_type blend_color(rgba_type base, logic [AMT_W-1:0] amount);
      int    t, d, m, s, total, i;
      int    b[3];
      int    c[3];
      int    res[3];
      rgba_type result;
      t = (amount > 256) ? 256 : int'(amount);
      b[0] = base.red;
      b[1] = base.green;
      b[2] = base.blue;
      c[0] = brush_red;
      c[1] = brush_green;
      c[2] = brush_blue;
      d = (54 * c[0] + 183 * c[1] + 19 * c[2]) - (54 * b[0] + 183 * b[1] + 19 * b[2]);
      for (i = 0; i < 3; i++) begin
         m = (b[i] * (256 - t) + c[i] * t + 128) >> 8;
         case (mode_setting)
            MODE_ADD: begin
               s = b[i] + ((c[i] * t + 128) >> 8);
               res[i] = (s > 255) ? 255 : s;
            end
            MODE_SUBTRACT: begin
               s = (c[i] * t + 128) >> 8;
               res[i] = (s > b[i]) ? 0 : b[i] - s;
            end
            MODE_MULTIPLY: begin
               res[i] = (b[i] * (255 * (256 - t) + c[i] * t) + 32640) / 65280;
            end
            MODE_LIGHTEN: begin
               res[i] = (m > b[i]) ? m : b[i];
            end
            MODE_DARKEN: begin
               res[i] = (m < b[i]) ? m : b[i];
            end
            MODE_COLOR: begin
               // Unrounded mix plus half the luminance shift, rounded once.
               total = (b[i] * (256 - t) + c[i] * t) * 512 + d * t + 65536;
               if (total < 0) begin
                  res[i] = 0;
               end else begin
                  res[i] = ((total >> 17) > 255) ? 255 : (total >> 17);
               end
            end
            default: begin
               res[i] = m;
            end
         endcase
      end
      result.red   = res[0][CH_W-1:0];
      result.green = res[1][CH_W-1:0];
      result.blue  = res[2][CH_W-1:0];
      if (mode_setting == MODE_MIX || mode_setting == MODE_SPARE) begin
         result.alpha = 8'((int'(base.alpha) * (256 - t) + int'(brush_alpha) * t + 128) >> 8);
      end else begin
         result.alpha = base.alpha;
      end
      return result;
   endfunction

   function automatic logic [CH_W-1:0] rand_channel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return CH_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [AMT_W-1:0] rand_amount();
      case ($urandom_range(9))
         0: return '0;
         1: return AMT_ONE;
         2: return AMT_W'($urandom_range(511, 257));
         default: return AMT_W'($urandom_range(256));
      endcase
   endfunction

   function automatic void check_channel(string name, logic [CH_W-1:0] expected,
                                         logic [CH_W-1:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            $error("rsp transfer with no expected color pending");
            error_count++;
         end else begin
            oldest_color = expected_colors.pop_front();
            check_channel("out_red", oldest_color.red, rsp_out_red);
            check_channel("out_green", oldest_color.green, rsp_out_green);
            check_channel("out_blue", oldest_color.blue, rsp_out_blue);
            check_channel("out_alpha", oldest_color.alpha, rsp_out_alpha);
         end
      end
   end

   // Sends one base color; valid stays high afterward so back-to-back transfers
   // need no extra edge.
   task automatic send_color(rgba_type base, logic [AMT_W-1:0] amount);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_base_red   <= base.red;
      req_base_green <= base.green;
      req_base_blue  <= base.blue;
      req_base_alpha <= base.alpha;
      req_mix_amount <= amount;
      do @(posedge clock); while (req_stall);
      expected_colors.push_back(blend_color(base, amount));
   endtask

   // Waits until every expected color has come back, with the request side quiet.
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CH_W-1:0] value);
      wait_for_idle();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      case (index)
         CSR_BLEND_MODE:  mode_setting = value[2:0];
         CSR_BRUSH_RED:   brush_red = value;
         CSR_BRUSH_GREEN: brush_green = value;
         CSR_BRUSH_BLUE:  brush_blue = value;
         CSR_BRUSH_ALPHA: brush_alpha = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_color({8'h80, 8'h40, 8'hC0, 8'h20}, 9'd128);
      send_color({8'hFF, 8'h01, 8'h7F, 8'h00}, AMT_ONE);
   endtask

   task automatic test_directed_modes();
      logic [2:0] mode;
      write_register(CSR_BRUSH_RED, 8'hFF);
      write_register(CSR_BRUSH_GREEN, 8'h00);
      write_register(CSR_BRUSH_BLUE, 8'hFF);
      write_register(CSR_BRUSH_ALPHA, 8'h40);
      for (int i = MODE_MIX; i <= MODE_COLOR; i++) begin
         mode = 3'(i);
         write_register(CSR_BLEND_MODE, CH_W'(mode));
         send_color({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 9'd0);
         // Amount far above one saturates; in color mode the red and blue clamp high.
         send_color({8'h00, 8'h00, 8'h00, 8'h00}, 9'd511);
         // Dark brush luminance against a green base drives color mode below zero.
         send_color({8'h00, 8'hFF, 8'h00, 8'h80}, 9'd257);
      end
   endtask

   task automatic test_register_decode();
      // Writes to indexes past the last register must leave every register alone.
      for (int idx = CSR_BRUSH_ALPHA + 1; idx < CSR_SLOTS; idx++) begin
         write_register(CSR_IDX_W'(idx), 8'hA5);
      end
      // Upper data bits beyond the mode field are dropped, leaving add here.
      write_register(CSR_BLEND_MODE, {5'b11111, MODE_ADD});
      send_color({8'hF0, 8'h10, 8'h80, 8'h33}, 9'd200);
      write_register(CSR_BLEND_MODE, CH_W'(MODE_SPARE));
      send_color({8'h10, 8'hF0, 8'h80, 8'hCC}, 9'd100);
   endtask

   task automatic test_random_traffic(int sender_pct, int receiver_pct, int item_count);
      int sent;
      int burst;
      int mode_code;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      sent = 0;
      mode_code = $urandom_range(CSR_SLOTS - 1);
      while (sent < item_count) begin
         write_register(CSR_BLEND_MODE, {5'($urandom_range(31)), 3'(mode_code)});
         write_register(CSR_BRUSH_RED, rand_channel());
         write_register(CSR_BRUSH_GREEN, rand_channel());
         write_register(CSR_BRUSH_BLUE, rand_channel());
         write_register(CSR_BRUSH_ALPHA, rand_channel());
         mode_code = (mode_code + 1) % CSR_SLOTS;
         burst = $urandom_range(45, 25);
         repeat (burst) begin
            send_color({rand_channel(), rand_channel(), rand_channel(), rand_channel()},
                       rand_amount());
         end
         sent += burst;
      end
   endtask

   initial begin
      int waited;
      reset          = 1'b1;
      csr_write      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      req_valid      = 1'b0;
      req_base_red   = '0;
      req_base_green = '0;
      req_base_blue  = '0;
      req_base_alpha = '0;
      req_mix_amount = '0;
      mode_setting   = MODE_MIX;
      brush_red      = '0;
      brush_green    = '0;
      brush_blue     = '0;
      brush_alpha    = 8'hFF;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_modes();
      test_register_decode();
      test_random_traffic(20, 63, ITEMS_PER_PHASE);
      test_random_traffic(63, 20, ITEMS_PER_PHASE);
      test_random_traffic(0, 0, ITEMS_PER_PHASE);

      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (expected_colors.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_colors.size() != 0) begin
         $error("%0d expected colors never arrived", expected_colors.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
